// ----- sv/assert_macros.svh -----
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies property in the same cycle
`define APJ_ASSERT_NOW(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle check failed");

// condition implies property in the next cycle
`define APJ_ASSERT_NEXT(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle check failed");

`endif

// ----- sv/apj_pkg.sv -----
// package with payload types, pipeline types and arithmetic helpers of the projector
`default_nettype none

package apj_pkg;

   localparam int SQRT_BITS    = 28;
   localparam int CORDIC_STEPS = 20;
   localparam int PCT_STEP     = 14;
   localparam int PCT_BUCKETS  = 6;
   localparam int PCT_SCALE    = 100;
   localparam int HALF_TURN_Q16 = 180 * 65536;
   localparam int ROW_OFFSET   = 45;
   localparam int COL_OFFSET   = 45;

   localparam logic signed [15:0] CAMERA_X_RESET = 16'sd0;
   localparam logic signed [15:0] CAMERA_Y_RESET = 16'sd0;
   localparam logic signed [15:0] CAMERA_Z_RESET = -16'sd50;

   typedef enum logic [1:0] {
      CSR_CAMERA_X = 2'd0,
      CSR_CAMERA_Y = 2'd1,
      CSR_CAMERA_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [7:0] point_x;
      logic signed [7:0] point_y;
      logic signed [7:0] point_z;
      logic              last_point;
   } req_type;

   typedef struct packed {
      logic [6:0] screen_column;
      logic [5:0] screen_row;
      logic [2:0] colour_index;
      logic       in_bounds;
      logic       last_result;
   } rsp_type;

   typedef struct packed {
      logic signed [47:0] x;
      logic signed [47:0] y;
      logic signed [25:0] z;
   } cordic_type;

   typedef struct packed {
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic signed [16:0] dz;
      logic [2:0]         colour;
      logic               last;
      logic [30:0]        sq_x;
      logic [30:0]        sq_z;
      cordic_type         azim;
      cordic_type         elev;
      logic [55:0]        rem;
      logic [27:0]        root;
      logic               az_zero;
      logic               el_zero;
      logic signed [9:0]  deg_az;
      logic signed [9:0]  deg_el;
   } pipe_type;

   function automatic logic signed [25:0] atan_deg(input logic [4:0] idx);
      logic signed [25:0] v;
      unique case (idx)
         5'd0:  v = 26'sd2949120;
         5'd1:  v = 26'sd1740967;
         5'd2:  v = 26'sd919879;
         5'd3:  v = 26'sd466945;
         5'd4:  v = 26'sd234379;
         5'd5:  v = 26'sd117304;
         5'd6:  v = 26'sd58666;
         5'd7:  v = 26'sd29335;
         5'd8:  v = 26'sd14668;
         5'd9:  v = 26'sd7334;
         5'd10: v = 26'sd3667;
         5'd11: v = 26'sd1833;
         5'd12: v = 26'sd917;
         5'd13: v = 26'sd458;
         5'd14: v = 26'sd229;
         5'd15: v = 26'sd115;
         5'd16: v = 26'sd57;
         5'd17: v = 26'sd29;
         5'd18: v = 26'sd14;
         5'd19: v = 26'sd7;
         default: v = 26'sd0;
      endcase
      return v;
   endfunction

   function automatic cordic_type cordic_step(input cordic_type c, input logic [4:0] idx);
      cordic_type         r;
      logic signed [47:0] xs;
      logic signed [47:0] ys;
      xs = c.x >>> idx;
      ys = c.y >>> idx;
      if (c.y >= 0) begin
         r.x = c.x + ys;
         r.y = c.y - xs;
         r.z = c.z + atan_deg(idx);
      end else begin
         r.x = c.x - ys;
         r.y = c.y + xs;
         r.z = c.z - atan_deg(idx);
      end
      return r;
   endfunction

   function automatic logic signed [9:0] round_deg(input logic signed [25:0] a);
      logic [25:0] mag;
      logic [25:0] sum;
      logic [9:0]  whole;
      mag   = a[25] ? 26'(-a) : 26'(a);
      sum   = mag + 26'd32768;
      whole = 10'(sum >> 16);
      return a[25] ? $signed(10'(-whole)) : $signed(whole);
   endfunction

endpackage

`default_nettype wire

// ----- sv/angular_point_projector_top.sv -----
// top level of the angular point projector: camera registers and projection pipeline
`default_nettype none
`include "assert_macros.svh"

// Projects one point per clock onto a grid of whole-degree pixels while no stalled
// result holds the pipeline. A transaction entering on req_ comes out on rsp_ in
// order. The 28-stage bit-per-stage square root for the horizontal radius is
// followed by the 20-stage elevation CORDIC; the azimuth CORDIC runs alongside the
// square root. A stalled result freezes the whole pipeline, so req_stall follows
// rsp_stall while a result is waiting. Camera registers must be written through
// csr_ while no point is in flight, a user rule that the block does not enforce.
module angular_point_projector_top #(
   parameter int SCREEN_WIDTH  = 90,
   parameter int SCREEN_HEIGHT = 45,
   parameter int HEIGHT_RADIUS = 35
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire apj_pkg::req_type req_data,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      apj_pkg::rsp_type rsp_data,
   input  wire logic            csr_wr_en,
   input  wire logic [1:0]      csr_index,
   input  wire logic [15:0]     csr_wr_data
);

   localparam int SQRT_FIRST  = 3;
   localparam int EL_INIT     = SQRT_FIRST + apj_pkg::SQRT_BITS;
   localparam int EL_FIRST    = EL_INIT + 1;
   localparam int ROUND_STAGE = EL_FIRST + apj_pkg::CORDIC_STEPS;
   localparam int NS          = ROUND_STAGE + 1;

   logic signed [15:0] camera_x_ff;
   logic signed [15:0] camera_y_ff;
   logic signed [15:0] camera_z_ff;

   apj_pkg::pipe_type pipe_ff [NS];
   apj_pkg::pipe_type pipe_in [NS];
   logic [NS-1:0]     valid_ff;
   logic [NS-1:0]     valid_in;

   apj_pkg::rsp_type  rsp_ff;
   apj_pkg::rsp_type  rsp_in;
   logic              rsp_valid_ff;
   logic              adv;

   // camera registers
   always_ff @(posedge clock) begin
      if (reset) begin
         camera_x_ff <= apj_pkg::CAMERA_X_RESET;
         camera_y_ff <= apj_pkg::CAMERA_Y_RESET;
         camera_z_ff <= apj_pkg::CAMERA_Z_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            apj_pkg::CSR_CAMERA_X: camera_x_ff <= csr_wr_data;
            apj_pkg::CSR_CAMERA_Y: camera_y_ff <= csr_wr_data;
            apj_pkg::CSR_CAMERA_Z: camera_z_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   assign valid_in[0] = req_valid;

   // offsets and colour bucket
   always_comb begin
      apj_pkg::pipe_type  p;
      logic signed [8:0]  lift;
      logic signed [16:0] pct;
      p      = '0;
      p.dx   = 17'(req_data.point_x) - 17'(camera_x_ff);
      p.dy   = 17'(req_data.point_y) - 17'(camera_y_ff);
      p.dz   = 17'(req_data.point_z) - 17'(camera_z_ff);
      p.last = req_data.last_point;
      lift   = 9'(req_data.point_y) + 9'(HEIGHT_RADIUS);
      pct    = 17'(lift) * 17'(apj_pkg::PCT_SCALE);
      p.colour = 3'd1;
      for (int k = 1; k <= apj_pkg::PCT_BUCKETS; k++) begin
         if (pct >= 17'((2 * k * apj_pkg::PCT_STEP - 1) * HEIGHT_RADIUS)) begin
            p.colour = p.colour + 3'd1;
         end
      end
      pipe_in[0] = p;
   end

   for (genvar k = 1; k < NS; k++) begin : g_stage
      assign valid_in[k] = valid_ff[k-1];

      if (k == 1) begin : g_square
         always_comb begin
            apj_pkg::pipe_type  p;
            logic signed [33:0] px2;
            logic signed [33:0] pz2;
            logic               neg;
            logic signed [16:0] mag;
            logic signed [16:0] yv;
            p   = pipe_ff[k-1];
            px2 = p.dx * p.dx;
            pz2 = p.dz * p.dz;
            p.sq_x = 31'(px2);
            p.sq_z = 31'(pz2);
            neg = p.dx[16];
            mag = neg ? -p.dx : p.dx;
            yv  = neg ? -p.dz : p.dz;
            p.azim.x = 48'(mag) << 28;
            p.azim.y = 48'(yv) << 28;
            if (!neg) begin
               p.azim.z = 26'sd0;
            end else if (!p.dz[16]) begin
               p.azim.z = 26'(apj_pkg::HALF_TURN_Q16);
            end else begin
               p.azim.z = 26'(-apj_pkg::HALF_TURN_Q16);
            end
            p.az_zero  = (p.dx == 17'sd0) && (p.dz == 17'sd0);
            pipe_in[k] = p;
         end
      end else if (k == 2) begin : g_sum
         always_comb begin
            apj_pkg::pipe_type p;
            logic [31:0]       n;
            p          = pipe_ff[k-1];
            n          = 32'(p.sq_x) + 32'(p.sq_z);
            p.rem      = {n, 24'd0};
            p.root     = '0;
            p.el_zero  = p.az_zero && (p.dy == 17'sd0);
            pipe_in[k] = p;
         end
      end else if (k < EL_INIT) begin : g_sqrt
         localparam int G   = k - SQRT_FIRST;
         localparam int BIT = apj_pkg::SQRT_BITS - 1 - G;
         always_comb begin
            apj_pkg::pipe_type p;
            logic [56:0]       trial;
            p     = pipe_ff[k-1];
            trial = (57'(p.root) << (BIT + 1)) + (57'd1 << (2 * BIT));
            if ({1'b0, p.rem} >= trial) begin
               p.rem       = 56'({1'b0, p.rem} - trial);
               p.root[BIT] = 1'b1;
            end
            if (G < apj_pkg::CORDIC_STEPS) begin
               p.azim = apj_pkg::cordic_step(p.azim, 5'(G));
            end
            pipe_in[k] = p;
         end
      end else if (k == EL_INIT) begin : g_el_init
         always_comb begin
            apj_pkg::pipe_type p;
            p          = pipe_ff[k-1];
            p.elev.x   = 48'({p.root, 16'd0});
            p.elev.y   = 48'(p.dy) << 28;
            p.elev.z   = 26'sd0;
            pipe_in[k] = p;
         end
      end else if (k < ROUND_STAGE) begin : g_elev
         always_comb begin
            apj_pkg::pipe_type p;
            p          = pipe_ff[k-1];
            p.elev     = apj_pkg::cordic_step(p.elev, 5'(k - EL_FIRST));
            pipe_in[k] = p;
         end
      end else begin : g_round
         always_comb begin
            apj_pkg::pipe_type p;
            p          = pipe_ff[k-1];
            p.deg_az   = p.az_zero ? 10'sd0 : apj_pkg::round_deg(p.azim.z);
            p.deg_el   = p.el_zero ? 10'sd0 : apj_pkg::round_deg(p.elev.z);
            pipe_in[k] = p;
         end
      end
   end

   // screen position and bounds
   always_comb begin
      logic signed [10:0] col;
      logic signed [10:0] row;
      logic               ok;
      col = 11'(pipe_ff[NS-1].deg_az) - 11'(apj_pkg::COL_OFFSET);
      row = 11'(pipe_ff[NS-1].deg_el) + 11'(apj_pkg::ROW_OFFSET);
      ok  = (col >= 11'sd0) && (col < $signed(11'(SCREEN_WIDTH)))
         && (row >= 11'sd0) && (row < $signed(11'(SCREEN_HEIGHT)));
      rsp_in.screen_column = ok ? col[6:0] : 7'd0;
      rsp_in.screen_row    = ok ? row[5:0] : 6'd0;
      rsp_in.colour_index  = pipe_ff[NS-1].colour;
      rsp_in.in_bounds     = ok;
      rsp_in.last_result   = pipe_ff[NS-1].last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff <= pipe_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `APJ_ASSERT_NOW(a_off_screen_zero, clock, reset, rsp_valid_ff && !rsp_ff.in_bounds,
      rsp_ff.screen_column == 7'd0 && rsp_ff.screen_row == 6'd0)
   `APJ_ASSERT_NOW(a_colour_nonzero, clock, reset, rsp_valid_ff,
      rsp_ff.colour_index != 3'd0)
   `APJ_ASSERT_NOW(a_on_screen_range, clock, reset, rsp_valid_ff && rsp_ff.in_bounds,
      32'(rsp_ff.screen_column) < SCREEN_WIDTH && 32'(rsp_ff.screen_row) < SCREEN_HEIGHT)
   `APJ_ASSERT_NEXT(a_stall_freezes, clock, reset, rsp_valid_ff && rsp_stall,
      $stable(valid_ff) && rsp_valid_ff)

endmodule

`default_nettype wire

// ----- dv/apj_checker.sv -----
// checker for the angular point projector: predicts each result and compares it
module apj_checker #(
   parameter int SCREEN_WIDTH  = 90,
   parameter int SCREEN_HEIGHT = 45,
   parameter int HEIGHT_RADIUS = 35
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  apj_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  apj_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wr_data,
   output int               fail_count,
   output int               pending_count
);

   localparam longint ATAN_Q16 [20] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

   longint cam_x, cam_y, cam_z;
   apj_pkg::rsp_type projected_q[$];

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint vector_angle(longint x, longint y);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 65536;
      y = y * 65536;
      for (int i = 0; i < 20; i++) begin
         xs = shift_floor(x, i);
         ys = shift_floor(y, i);
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + ATAN_Q16[i];
         end else begin
            x = x - ys; y = y + xs; z = z - ATAN_Q16[i];
         end
      end
      return z;
   endfunction

   function automatic longint whole_degrees(longint a);
      if (a >= 0) return (a + 32768) >>> 16;
      return -((-a + 32768) >>> 16);
   endfunction

   function automatic longint isqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b); r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic apj_pkg::rsp_type project_point(apj_pkg::req_type p);
      apj_pkg::rsp_type o;
      longint dx, dy, dz, az, el, col, row, n, d, pct;
      longint unsigned r;
      bit ok;
      dx = longint'(p.point_x) - cam_x;
      dy = longint'(p.point_y) - cam_y;
      dz = longint'(p.point_z) - cam_z;
      if (dx >= 0) az = vector_angle(dx * 4096, dz * 4096);
      else az = (dz >= 0 ? 180 * 65536 : -180 * 65536)
                + vector_angle(-dx * 4096, -dz * 4096);
      r = isqrt(longint'(dx * dx + dz * dz) << 24);
      el = vector_angle(longint'(r), dy * 4096);
      col = whole_degrees(az) - 45;
      row = whole_degrees(el) + 45;
      ok = col >= 0 && col < SCREEN_WIDTH && row >= 0 && row < SCREEN_HEIGHT;
      n = (longint'(p.point_y) + HEIGHT_RADIUS) * 100;
      d = 2 * HEIGHT_RADIUS;
      if (n >= 0) pct = (2 * n + d) / (2 * d);
      else pct = -((-2 * n + d) / (2 * d));
      o.screen_column = ok ? col[6:0] : '0;
      o.screen_row    = ok ? row[5:0] : '0;
      o.colour_index  = pct < 14 ? 3'd1 : pct < 28 ? 3'd2 : pct < 42 ? 3'd3 :
                        pct < 56 ? 3'd4 : pct < 70 ? 3'd5 : pct < 84 ? 3'd6 : 3'd7;
      o.in_bounds     = ok;
      o.last_result   = p.last_point;
      return o;
   endfunction

   assign pending_count = projected_q.size();

   always @(posedge clock) begin
      apj_pkg::rsp_type exp_rsp;
      if (reset) begin
         cam_x = apj_pkg::CAMERA_X_RESET;
         cam_y = apj_pkg::CAMERA_Y_RESET;
         cam_z = apj_pkg::CAMERA_Z_RESET;
         projected_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (projected_q.size() == 0) begin
               $error("unexpected transaction %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = projected_q.pop_front();
               if (rsp_data !== exp_rsp) begin
                  if (rsp_data.screen_column !== exp_rsp.screen_column)
                     $error("screen_column exp %0d got %0d",
                            exp_rsp.screen_column, rsp_data.screen_column);
                  if (rsp_data.screen_row !== exp_rsp.screen_row)
                     $error("screen_row exp %0d got %0d",
                            exp_rsp.screen_row, rsp_data.screen_row);
                  if (rsp_data.colour_index !== exp_rsp.colour_index)
                     $error("colour_index exp %0d got %0d",
                            exp_rsp.colour_index, rsp_data.colour_index);
                  if (rsp_data.in_bounds !== exp_rsp.in_bounds)
                     $error("in_bounds exp %0d got %0d",
                            exp_rsp.in_bounds, rsp_data.in_bounds);
                  if (rsp_data.last_result !== exp_rsp.last_result)
                     $error("last_result exp %0d got %0d",
                            exp_rsp.last_result, rsp_data.last_result);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) projected_q.push_back(project_point(req_data));
         if (csr_wr_en) begin
            case (csr_index)
               apj_pkg::CSR_CAMERA_X: cam_x = longint'($signed(csr_wr_data));
               apj_pkg::CSR_CAMERA_Y: cam_y = longint'($signed(csr_wr_data));
               apj_pkg::CSR_CAMERA_Z: cam_z = longint'($signed(csr_wr_data));
               default: ;
            endcase
         end
      end
   end
endmodule

// ----- dv/tb_angular_point_projector_top.sv -----
// testbench top for the angular point projector: stimulus, camera settings and verdict
module tb_angular_point_projector_top;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   apj_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 0;
   apj_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 0;
   logic [1:0]       csr_index = '0;
   logic [15:0]      csr_wr_data = '0;
   int               fail_count;
   int               pending_count;
   bit               stall_on = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   angular_point_projector_top u_top (.*);

   apj_checker u_checker (.*);

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // random stall on the result side
   always @(posedge clock) begin
      if (!stall_on) rsp_stall <= 1'b0;
      else if ($urandom_range(0, 19) == 0) rsp_stall <= ($urandom_range(0, 3) != 0);
      else if (!rsp_stall) rsp_stall <= ($urandom_range(0, 5) == 0);
      else rsp_stall <= ($urandom_range(0, 2) == 0);
   end

   task automatic send_point(apj_pkg::req_type p);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_camera(apj_pkg::csr_index_type idx, logic [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic apj_pkg::req_type near_point();
      apj_pkg::req_type p;
      p.point_x    = 8'($urandom_range(0, 255));
      p.point_y    = 8'($signed($urandom_range(0, 90)) - 45);
      p.point_z    = 8'($urandom_range(0, 255));
      p.last_point = 1'($urandom_range(0, 1));
      return p;
   endfunction

   function automatic apj_pkg::req_type any_point();
      apj_pkg::req_type p;
      p.point_x    = 8'($urandom);
      p.point_y    = 8'($urandom);
      p.point_z    = 8'($urandom);
      p.last_point = 1'($urandom);
      return p;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++)
         send_point($urandom_range(0, 1) ? near_point() : any_point());
      drain();
   endtask

   initial begin
      logic signed [7:0] ends [5];
      ends = '{-128, -1, 0, 1, 127};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      stall_on = 1;
      // directed: field extremes and other fixed points at reset camera
      foreach (ends[i]) send_point('{ends[i], ends[(i + 1) % 5], ends[(i + 2) % 5], 1'b0});
      send_point('{8'sd127, 8'sd127, 8'sd127, 1'b1});
      send_point('{-8'sd128, -8'sd128, -8'sd128, 1'b0});
      send_point('{8'sd0, 8'sd0, 8'sd0, 1'b1});
      send_point('{-8'sd10, 8'sd0, -8'sd50, 1'b0});
      drain();
      // zero vector in both angles and in azimuth alone, after a write to an unused csr index
      write_camera(apj_pkg::CSR_CAMERA_X, 16'd5);
      write_camera(apj_pkg::CSR_CAMERA_Y, 16'd7);
      write_camera(apj_pkg::CSR_CAMERA_Z, 16'd9);
      write_camera(apj_pkg::csr_index_type'(2'd3), 16'h1234);
      send_point('{8'sd5, 8'sd7, 8'sd9, 1'b0});
      send_point('{8'sd5, 8'sd20, 8'sd9, 1'b1});
      send_point('{8'sd5, -8'sd20, 8'sd9, 1'b0});
      send_point('{-8'sd100, 8'sd7, 8'sd9, 1'b0});
      send_point('{8'sd5, 8'sd7, -8'sd128, 1'b1});
      drain();
      write_camera(apj_pkg::CSR_CAMERA_X, 16'h7fff);
      write_camera(apj_pkg::CSR_CAMERA_Y, 16'h8000);
      write_camera(apj_pkg::CSR_CAMERA_Z, 16'h7fff);
      random_phase(30);
      write_camera(apj_pkg::CSR_CAMERA_X, 16'h8000);
      write_camera(apj_pkg::CSR_CAMERA_Y, 16'h7fff);
      write_camera(apj_pkg::CSR_CAMERA_Z, 16'h8000);
      random_phase(30);
      write_camera(apj_pkg::CSR_CAMERA_X, 16'hffff);
      write_camera(apj_pkg::CSR_CAMERA_Y, 16'hffff);
      write_camera(apj_pkg::CSR_CAMERA_Z, 16'hffff);
      random_phase(30);
      write_camera(apj_pkg::CSR_CAMERA_X, 16'd0);
      write_camera(apj_pkg::CSR_CAMERA_Y, 16'd0);
      write_camera(apj_pkg::CSR_CAMERA_Z, 16'hffce);
      random_phase(500);
      write_camera(apj_pkg::CSR_CAMERA_X, 16'($urandom_range(0, 200) - 100));
      write_camera(apj_pkg::CSR_CAMERA_Y, 16'($urandom_range(0, 200) - 100));
      write_camera(apj_pkg::CSR_CAMERA_Z, 16'($urandom_range(0, 400) - 200));
      random_phase(200);
      stall_on = 0;
      write_camera(apj_pkg::CSR_CAMERA_Z, 16'hff00);
      random_phase(150);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/apj_pkg.sv
sv/angular_point_projector_top.sv
dv/apj_checker.sv
dv/tb_angular_point_projector_top.sv
